// File: rtl/core/gbpb_pkg.sv
// ----------------------------------------------------------------------------
// Glyph byte pixel blitter package
// Shared constants, register indexes and stage payload types.
// ----------------------------------------------------------------------------
package gbpb_pkg;

   // Largest surface dimension; larger register values act as this.
   localparam int MAX_SURFACE_DIM = 4096;
   // Byte positions at or above this yield no pixel writes.
   localparam int MAX_ROW_BYTES   = 32;
   localparam int BITS_PER_BYTE   = 8;

   localparam int DIM_W    = 13;
   localparam int COORD_W  = 12;
   localparam int PITCH_W  = 16;
   localparam int BPP_W    = 3;
   localparam int COLOR_W  = 32;
   localparam int OFFSET_W = 28;
   localparam int LANE_W   = 3;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SURFACE_WIDTH   = 3'd0,
      CSR_SURFACE_HEIGHT  = 3'd1,
      CSR_ROW_PITCH       = 3'd2,
      CSR_BYTES_PER_PIXEL = 3'd3,
      CSR_PIXEL_COLOR     = 3'd4
   } csr_index_type;

   // One glyph byte after clipping, waiting to be split into pixel writes.
   typedef struct packed {
      logic [BITS_PER_BYTE-1:0] lane_mask;
      logic [COORD_W-1:0]       x_base;
      logic [COORD_W-1:0]       y;
      logic [OFFSET_W-1:0]      row_base;
   } lane_item_type;

   // One pixel write before the final offset add.
   typedef struct packed {
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [OFFSET_W-1:0] row_base;
      logic                last;
   } pixel_type;

endpackage

// File: rtl/core/gbpb_serializer.sv
// ----------------------------------------------------------------------------
// Glyph byte pixel serializer
// Holds one clipped glyph byte and issues one pixel write per cycle while
// out_ready is high, lowest lit lane first, flagging the final write of the byte.
// ----------------------------------------------------------------------------
module gbpb_serializer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  gbpb_pkg::lane_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output gbpb_pkg::pixel_type     out_pixel
);

   logic                                 valid_ff, valid_in;
   logic [gbpb_pkg::BITS_PER_BYTE-1:0]   mask_ff, mask_in;
   logic [gbpb_pkg::COORD_W-1:0]         x_base_ff;
   logic [gbpb_pkg::COORD_W-1:0]         y_ff;
   logic [gbpb_pkg::OFFSET_W-1:0]        row_base_ff;
   logic [gbpb_pkg::LANE_W-1:0]          lane_sel;
   logic [gbpb_pkg::BITS_PER_BYTE-1:0]   mask_rest;
   logic                                 is_last;
   logic                                 emit;
   logic                                 load;

   // Pick the lowest lit lane of the held byte.
   always_comb begin
      lane_sel = '0;
      for (int k = gbpb_pkg::BITS_PER_BYTE - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            lane_sel = gbpb_pkg::LANE_W'(k);
         end
      end
   end

   assign mask_rest = mask_ff & (mask_ff - gbpb_pkg::BITS_PER_BYTE'(1));
   assign is_last   = (mask_rest == '0);
   assign emit      = valid_ff && out_ready;
   assign in_ready  = !valid_ff || (out_ready && is_last);
   assign load      = in_valid && in_ready;

   // Next held byte: a new one, the remaining lanes, or empty.
   always_comb begin
      valid_in = valid_ff;
      mask_in  = mask_ff;
      if (load) begin
         valid_in = 1'b1;
         mask_in  = in_item.lane_mask;
      end else if (emit) begin
         valid_in = !is_last;
         mask_in  = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (load) begin
         x_base_ff   <= in_item.x_base;
         y_ff        <= in_item.y;
         row_base_ff <= in_item.row_base;
      end
   end

   assign out_valid          = valid_ff;
   assign out_pixel.x        = x_base_ff + gbpb_pkg::COORD_W'(lane_sel);
   assign out_pixel.y        = y_ff;
   assign out_pixel.row_base = row_base_ff;
   assign out_pixel.last     = is_last;

endmodule

// File: rtl/core/glyph_byte_pixel_blitter.sv
// ----------------------------------------------------------------------------
// Path: a byte passes the input register, stages 2 and 3, the serializer and
// the output register; later writes of it follow one per cycle unless stalled.
// Throughput: while rsp_stall is low, a byte with at most one write is taken
// every cycle; more writes (eight at most) hold the serializer till the last.
// Reset: synchronous, active high; empties the pipeline and loads the
// register defaults (640 x 480, pitch 2560, four bytes per pixel, color 0).
// ----------------------------------------------------------------------------
// Glyph byte pixel blitter
// Turns one byte of a 1-bit glyph bitmap into clipped pixel writes with
// their byte offsets in the destination surface.
// ----------------------------------------------------------------------------
module glyph_byte_pixel_blitter (
   input  logic                                 clock,
   input  logic                                 reset,
   // Glyph byte input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [gbpb_pkg::BITS_PER_BYTE-1:0]   req_glyph_bits,
   input  logic signed [15:0]                   req_origin_x,
   input  logic signed [15:0]                   req_origin_y,
   input  logic [7:0]                           req_glyph_row,
   input  logic [4:0]                           req_row_byte,
   // Pixel write output channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [gbpb_pkg::OFFSET_W-1:0]        rsp_pixel_offset,
   output logic [gbpb_pkg::COORD_W-1:0]         rsp_pixel_x,
   output logic [gbpb_pkg::COORD_W-1:0]         rsp_pixel_y,
   output logic [gbpb_pkg::COLOR_W-1:0]         rsp_write_color,
   output logic                                 rsp_last_of_byte,
   // Configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gbpb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                          csr_data
);

   // Configuration registers.
   logic [gbpb_pkg::DIM_W-1:0]    surface_width_ff;
   logic [gbpb_pkg::DIM_W-1:0]    surface_height_ff;
   logic [gbpb_pkg::PITCH_W-1:0]  row_pitch_ff;
   logic [gbpb_pkg::BPP_W-1:0]    bytes_per_pixel_ff;
   logic [gbpb_pkg::COLOR_W-1:0]  pixel_color_ff;

   logic [gbpb_pkg::DIM_W-1:0]    width_eff;
   logic [gbpb_pkg::DIM_W-1:0]    height_eff;
   logic                          bpp_ok;

   // Stage 1: registered input transaction.
   logic                                 s1_valid_ff;
   logic [gbpb_pkg::BITS_PER_BYTE-1:0]   s1_bits_ff;
   logic [15:0]                          s1_origin_x_ff;
   logic [15:0]                          s1_origin_y_ff;
   logic [7:0]                           s1_row_ff;
   logic [4:0]                           s1_row_byte_ff;
   logic                                 s1_ready;

   // Stage 2: absolute row and first column, row checks done.
   logic                                 s2_valid_ff, s2_valid_in;
   logic [gbpb_pkg::BITS_PER_BYTE-1:0]   s2_bits_ff;
   logic [17:0]                          s2_x0_ff, s2_x0_in;
   logic [gbpb_pkg::COORD_W-1:0]         s2_y_ff;
   logic [16:0]                          s2_y_in;
   logic                                 s2_ready;

   // Stage 3: lit lanes inside the surface and row base offset.
   logic                                 s3_valid_ff, s3_valid_in;
   gbpb_pkg::lane_item_type              s3_item_ff, s3_item_in;
   logic                                 s3_ready;

   // Serializer to output stage.
   logic                                 ser_in_ready;
   logic                                 ser_out_valid;
   gbpb_pkg::pixel_type                  ser_pixel;

   // Output register.
   logic                                 out_valid_ff;
   logic [gbpb_pkg::OFFSET_W-1:0]        out_offset_ff;
   logic [gbpb_pkg::COORD_W-1:0]         out_x_ff;
   logic [gbpb_pkg::COORD_W-1:0]         out_y_ff;
   logic [gbpb_pkg::COLOR_W-1:0]         out_color_ff;
   logic                                 out_last_ff;
   logic                                 out_ready;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_width_ff   <= gbpb_pkg::DIM_W'(640);
         surface_height_ff  <= gbpb_pkg::DIM_W'(480);
         row_pitch_ff       <= gbpb_pkg::PITCH_W'(2560);
         bytes_per_pixel_ff <= gbpb_pkg::BPP_W'(4);
         pixel_color_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (gbpb_pkg::csr_index_type'(csr_index))
            gbpb_pkg::CSR_SURFACE_WIDTH: begin
               surface_width_ff <= csr_data[gbpb_pkg::DIM_W-1:0];
            end
            gbpb_pkg::CSR_SURFACE_HEIGHT: begin
               surface_height_ff <= csr_data[gbpb_pkg::DIM_W-1:0];
            end
            gbpb_pkg::CSR_ROW_PITCH: begin
               row_pitch_ff <= csr_data[gbpb_pkg::PITCH_W-1:0];
            end
            gbpb_pkg::CSR_BYTES_PER_PIXEL: begin
               bytes_per_pixel_ff <= csr_data[gbpb_pkg::BPP_W-1:0];
            end
            gbpb_pkg::CSR_PIXEL_COLOR: begin
               pixel_color_ff <= csr_data[gbpb_pkg::COLOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Oversized surfaces act as the largest supported one.
   assign width_eff  = (surface_width_ff > gbpb_pkg::DIM_W'(gbpb_pkg::MAX_SURFACE_DIM))
                     ? gbpb_pkg::DIM_W'(gbpb_pkg::MAX_SURFACE_DIM) : surface_width_ff;
   assign height_eff = (surface_height_ff > gbpb_pkg::DIM_W'(gbpb_pkg::MAX_SURFACE_DIM))
                     ? gbpb_pkg::DIM_W'(gbpb_pkg::MAX_SURFACE_DIM) : surface_height_ff;
   assign bpp_ok     = bytes_per_pixel_ff inside {[3'd1:3'd4]};

   // Handshake chain: a stage takes new data when empty or when it moves on.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || ser_in_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   // Stage 1: capture the input transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_bits_ff     <= req_glyph_bits;
         s1_origin_x_ff <= req_origin_x;
         s1_origin_y_ff <= req_origin_y;
         s1_row_ff      <= req_glyph_row;
         s1_row_byte_ff <= req_row_byte;
      end
   end

   // Stage 2: absolute row and first column; drop bytes whose row clips or whose pixel size or byte position is bad.
   always_comb begin
      s2_y_in  = {s1_origin_y_ff[15], s1_origin_y_ff} + {9'd0, s1_row_ff};
      s2_x0_in = {{2{s1_origin_x_ff[15]}}, s1_origin_x_ff}
               + {10'd0, s1_row_byte_ff, 3'd0};
      s2_valid_in = s1_valid_ff && bpp_ok
                 && ({4'd0, s1_row_byte_ff} < 9'(gbpb_pkg::MAX_ROW_BYTES))
                 && !s2_y_in[16]
                 && (s2_y_in[15:0] < {3'd0, height_eff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_bits_ff <= s1_bits_ff;
         s2_x0_ff   <= s2_x0_in;
         s2_y_ff    <= s2_y_in[gbpb_pkg::COORD_W-1:0];
      end
   end

   // Stage 3: per-lane column clip and the row base multiply.
   always_comb begin
      logic [17:0] x_lane;
      x_lane = '0;
      for (int k = 0; k < gbpb_pkg::BITS_PER_BYTE; k++) begin
         x_lane = s2_x0_ff + 18'(k);
         s3_item_in.lane_mask[k] = s2_bits_ff[k] && !x_lane[17]
                                && (x_lane[16:0] < {4'd0, width_eff});
      end
      s3_item_in.x_base   = s2_x0_ff[gbpb_pkg::COORD_W-1:0];
      s3_item_in.y        = s2_y_ff;
      s3_item_in.row_base = gbpb_pkg::OFFSET_W'(s2_y_ff)
                          * gbpb_pkg::OFFSET_W'(row_pitch_ff);
      s3_valid_in = s2_valid_ff && (s3_item_in.lane_mask != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_item_ff <= s3_item_in;
      end
   end

   // Stage 4: one pixel write per cycle from the held byte while out_ready is high.
   gbpb_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_ready  (ser_in_ready),
      .in_item   (s3_item_ff),
      .out_valid (ser_out_valid),
      .out_ready (out_ready),
      .out_pixel (ser_pixel)
   );

   // Stage 5: final offset add into the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= ser_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && ser_out_valid) begin
         out_offset_ff <= ser_pixel.row_base
                        + {13'd0, 15'(ser_pixel.x) * 15'(bytes_per_pixel_ff)};
         out_x_ff      <= ser_pixel.x;
         out_y_ff      <= ser_pixel.y;
         out_color_ff  <= pixel_color_ff;
         out_last_ff   <= ser_pixel.last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_offset = out_offset_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_write_color  = out_color_ff;
   assign rsp_last_of_byte = out_last_ff;

endmodule

// File: rtl/core/gbpb_port_checker.sv
// ----------------------------------------------------------------------------
// Glyph byte pixel blitter port checker
// Watches the top-level ports and flags behavior the pipeline must not show.
// ----------------------------------------------------------------------------
module gbpb_port_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [gbpb_pkg::OFFSET_W-1:0]       rsp_pixel_offset,
   input logic [gbpb_pkg::COORD_W-1:0]        rsp_pixel_x,
   input logic [gbpb_pkg::COORD_W-1:0]        rsp_pixel_y,
   input logic [gbpb_pkg::COLOR_W-1:0]        rsp_write_color,
   input logic                                rsp_last_of_byte
);

   // Reset empties the pipeline, so no pixel write shows right after it.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel write presented right after reset");

   // A stalled pixel write holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_offset)
         && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
         && $stable(rsp_last_of_byte))
      else $error("stalled pixel write changed");

   // The writes of one byte come back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_byte |=> rsp_valid)
      else $error("gap inside the pixel writes of one byte");

   // Within one byte the row holds and the column rises.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_byte |=>
         rsp_pixel_y == $past(rsp_pixel_y) && rsp_pixel_x > $past(rsp_pixel_x)
         && rsp_write_color == $past(rsp_write_color))
      else $error("pixel writes of one byte out of order");

endmodule

bind glyph_byte_pixel_blitter gbpb_port_checker u_port_checker (.*);

// File: tb/sv/glyph_byte_pixel_blitter_tb.sv
// ----------------------------------------------------------------------------
// Glyph byte pixel blitter testbench
// Drives glyph bitmap bytes through the blitter under several surface
// settings and checks every pixel write against a local prediction of the
// clipped pixels, their byte offsets, colors and last-of-byte flags. Both
// channels idle and stall at random, and the receiver holds off long enough
// to fill the pipeline.
// ----------------------------------------------------------------------------
module glyph_byte_pixel_blitter_tb;
   import gbpb_pkg::*;

   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int SETTLE_CYCLES     = 16;
   localparam int STALL_HOLD_CYCLES = 150;
   localparam int IDLE_PERCENT      = 13;
   localparam int RANDOM_PHASES     = 5;
   localparam int BYTES_PER_PHASE   = 16;
   localparam int MAX_REPORTS       = 10;
   // Index past the last register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COLOR_W-1:0]  color;
      logic                last;
   } pixel_write_type;

   // Tracks the surface registers and the pixel writes still owed by the block.
   class pixel_write_scoreboard;
      logic [DIM_W-1:0]   width_reg;
      logic [DIM_W-1:0]   height_reg;
      logic [PITCH_W-1:0] pitch_reg;
      logic [BPP_W-1:0]   bpp_reg;
      logic [COLOR_W-1:0] color_reg;
      pixel_write_type    expected_writes[$];
      int                 error_count;
      int                 checked_count;

      function void load_defaults();
         width_reg  = 640;
         height_reg = 480;
         pitch_reg  = 2560;
         bpp_reg    = 4;
         color_reg  = '0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [31:0] data);
         case (index)
            CSR_SURFACE_WIDTH:   width_reg  = data[DIM_W-1:0];
            CSR_SURFACE_HEIGHT:  height_reg = data[DIM_W-1:0];
            CSR_ROW_PITCH:       pitch_reg  = data[PITCH_W-1:0];
            CSR_BYTES_PER_PIXEL: bpp_reg    = data[BPP_W-1:0];
            CSR_PIXEL_COLOR:     color_reg  = data[COLOR_W-1:0];
            default: ;
         endcase
      endfunction

      // Works out the clipped pixel writes caused by one accepted glyph byte.
      function void note_byte(logic [7:0] bits, logic signed [15:0] origin_x,
                              logic signed [15:0] origin_y, logic [7:0] glyph_row,
                              logic [4:0] row_byte);
         int              w_lim, h_lim, x_pos, y_pos, pitch_i, bpp_i, row_i, col_i, offset_i;
         pixel_write_type pw;
         pixel_write_type writes[$];
         w_lim = int'(width_reg);
         h_lim = int'(height_reg);
         if (w_lim > MAX_SURFACE_DIM) w_lim = MAX_SURFACE_DIM;
         if (h_lim > MAX_SURFACE_DIM) h_lim = MAX_SURFACE_DIM;
         pitch_i = int'(pitch_reg);
         bpp_i   = int'(bpp_reg);
         row_i   = int'(glyph_row);
         col_i   = int'(row_byte);
         if (bpp_i < 1 || bpp_i > 4) return;
         if (col_i >= MAX_ROW_BYTES) return;
         y_pos = int'(origin_y);
         y_pos = y_pos + row_i;
         if (y_pos < 0 || y_pos >= h_lim) return;
         for (int k = 0; k < BITS_PER_BYTE; k++) begin
            if (bits[k]) begin
               x_pos = int'(origin_x);
               x_pos = x_pos + BITS_PER_BYTE * col_i + k;
               if (x_pos >= 0 && x_pos < w_lim) begin
                  offset_i  = y_pos * pitch_i + x_pos * bpp_i;
                  pw.offset = offset_i[OFFSET_W-1:0];
                  pw.x      = x_pos[COORD_W-1:0];
                  pw.y      = y_pos[COORD_W-1:0];
                  pw.color  = color_reg;
                  pw.last   = 1'b0;
                  writes.push_back(pw);
               end
            end
         end
         if (writes.size() > 0) writes[writes.size() - 1].last = 1'b1;
         foreach (writes[i]) expected_writes.push_back(writes[i]);
      endfunction

      // Compares one accepted pixel write with the oldest one owed.
      function void check_write(pixel_write_type got);
         pixel_write_type want;
         if (expected_writes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR: unexpected pixel write offset=%h x=%0d y=%0d color=%h last=%b",
                        got.offset, got.x, got.y, got.color, got.last);
            return;
         end
         want = expected_writes.pop_front();
         checked_count++;
         if (got.offset !== want.offset || got.x !== want.x || got.y !== want.y ||
             got.color !== want.color || got.last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("ERROR: pixel write %0d mismatch", checked_count);
               $display("   expected offset=%h x=%0d y=%0d color=%h last=%b",
                        want.offset, want.x, want.y, want.color, want.last);
               $display("   actual   offset=%h x=%0d y=%0d color=%h last=%b",
                        got.offset, got.x, got.y, got.color, got.last);
            end
         end
      endfunction
   endclass

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_glyph_bits = '0;
   logic signed [15:0]    req_origin_x   = '0;
   logic signed [15:0]    req_origin_y   = '0;
   logic [7:0]            req_glyph_row  = '0;
   logic [4:0]            req_row_byte   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [OFFSET_W-1:0]   rsp_pixel_offset;
   logic [COORD_W-1:0]    rsp_pixel_x;
   logic [COORD_W-1:0]    rsp_pixel_y;
   logic [COLOR_W-1:0]    rsp_write_color;
   logic                  rsp_last_of_byte;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [31:0]           csr_data       = '0;

   bit                    steady_phase      = 1'b0;
   bit                    long_hold_pending = 1'b0;
   int                    bytes_sent        = 0;
   int                    settings_used     = 1;
   pixel_write_scoreboard blit_check;

   glyph_byte_pixel_blitter uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_glyph_bits   (req_glyph_bits),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_glyph_row    (req_glyph_row),
      .req_row_byte     (req_row_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_offset (rsp_pixel_offset),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_write_color  (rsp_write_color),
      .rsp_last_of_byte (rsp_last_of_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   // Offers one glyph byte, sometimes after idle cycles, and waits for the transaction.
   task automatic send_byte(logic [7:0] bits, logic signed [15:0] origin_x,
                            logic signed [15:0] origin_y, logic [7:0] glyph_row,
                            logic [4:0] row_byte);
      while (!steady_phase && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_glyph_bits <= bits;
      req_origin_x   <= origin_x;
      req_origin_y   <= origin_y;
      req_glyph_row  <= glyph_row;
      req_row_byte   <= row_byte;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      blit_check.note_byte(bits, origin_x, origin_y, glyph_row, row_byte);
      bytes_sent++;
   endtask

   // Random byte, usually aimed so that its pixels straddle the surface edges.
   task automatic send_random_byte();
      int          w_lim, h_lim, col_i, row_i, tx, ty;
      logic [31:0] rnd_x, rnd_y, rnd_misc;
      w_lim    = int'(blit_check.width_reg);
      h_lim    = int'(blit_check.height_reg);
      rnd_misc = $urandom;
      col_i    = int'(rnd_misc[12:8]);
      row_i    = int'(rnd_misc[23:16]);
      if (w_lim > MAX_SURFACE_DIM) w_lim = MAX_SURFACE_DIM;
      if (h_lim > MAX_SURFACE_DIM) h_lim = MAX_SURFACE_DIM;
      if ($urandom_range(99) < 10) begin
         rnd_x = $urandom;
         rnd_y = $urandom;
         send_byte(rnd_misc[7:0], rnd_x[15:0], rnd_y[15:0], rnd_misc[23:16], rnd_misc[12:8]);
      end else begin
         tx = int'($urandom_range(w_lim + 16)) - 8 - BITS_PER_BYTE * col_i;
         ty = int'($urandom_range(h_lim + 4)) - 2 - row_i;
         send_byte(rnd_misc[7:0], tx[15:0], ty[15:0], rnd_misc[23:16], rnd_misc[12:8]);
      end
   endtask

   // Stops offering bytes and waits until every owed write has come and the pipe is quiet.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (blit_check.expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      blit_check.set_register(index, data);
   endtask

   task automatic program_surface(int width, int height, int pitch, int bpp,
                                  logic [31:0] color);
      write_reg(CSR_SURFACE_WIDTH, width);
      write_reg(CSR_SURFACE_HEIGHT, height);
      write_reg(CSR_ROW_PITCH, pitch);
      write_reg(CSR_BYTES_PER_PIXEL, bpp);
      write_reg(CSR_PIXEL_COLOR, color);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic int pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 4) return 0;
      if (r < 12) return $urandom_range(8191, MAX_SURFACE_DIM + 1);
      if (r < 20) return MAX_SURFACE_DIM;
      if (r < 40) return $urandom_range(16, 1);
      return $urandom_range(MAX_SURFACE_DIM, 1);
   endfunction

   // Pixel write sink: checks each transaction and decides the next stall.
   initial begin : pixel_sink
      int              hold_left;
      pixel_write_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.offset = rsp_pixel_offset;
            got.x      = rsp_pixel_x;
            got.y      = rsp_pixel_y;
            got.color  = rsp_write_color;
            got.last   = rsp_last_of_byte;
            blit_check.check_write(got);
         end
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left         = STALL_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady_phase && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Watchdog: ends the run when no transaction of any kind happens for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int r, width, height, pitch, bpp;
      blit_check = new;
      blit_check.load_defaults();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Default surface: full byte, empty byte, and clipping on every side.
      send_byte(8'hFF, 0, 0, 0, 0);
      send_byte(8'h00, 10, 10, 0, 0);
      send_byte(8'h81, -4, 5, 0, 0);
      send_byte(8'hFF, 636, 479, 0, 0);
      send_byte(8'hFF, 0, 479, 1, 0);
      send_byte(8'h3C, 0, -1, 0, 0);
      send_byte(8'h0F, 0, -1, 1, 0);
      send_byte(8'hFF, 0, 0, 255, 31);
      send_byte(8'hFF, 16'h7FFF, 16'h7FFF, 255, 31);
      send_byte(8'hFF, 16'h8000, 16'h8000, 0, 31);
      send_byte(8'h55, 100, 200, 7, 3);
      send_byte(8'hAA, 100, 200, 7, 4);
      wait_drained();

      // Oversized surface with the widest pitch: far corner and largest offsets.
      write_reg(CSR_UNUSED_INDEX, 32'hFFFF_FFFF);
      program_surface(8191, MAX_SURFACE_DIM, 65535, 1, 32'hFFFF_FFFF);
      send_byte(8'hFF, 4090, 4095, 0, 0);
      send_byte(8'hFF, 3840, 4000, 95, 31);
      wait_drained();

      // One-pixel surface with zero pitch.
      program_surface(1, 1, 0, 2, 32'h0000_0000);
      send_byte(8'hFF, 0, 0, 0, 0);
      send_byte(8'hFE, 0, 0, 0, 0);
      wait_drained();

      // Empty surfaces clip everything.
      program_surface(0, 480, 2560, 3, 32'h1234_5678);
      send_byte(8'hFF, 0, 0, 0, 0);
      wait_drained();
      program_surface(640, 0, 2560, 3, 32'h8765_4321);
      send_byte(8'hFF, 0, 0, 0, 0);
      wait_drained();

      // Bad pixel sizes yield nothing.
      program_surface(640, 480, 2560, 0, 32'hA5A5_A5A5);
      send_byte(8'hFF, 0, 0, 0, 0);
      wait_drained();
      program_surface(640, 480, 2560, 5, 32'h5A5A_5A5A);
      send_byte(8'hFF, 8, 8, 0, 0);
      wait_drained();
      program_surface(640, 480, 2560, 7, 32'hFFFF_0000);
      send_byte(8'hFF, 8, 8, 0, 0);
      wait_drained();

      // Random phases, each under a fresh random surface setting.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         width  = pick_dim();
         height = pick_dim();
         r      = $urandom_range(99);
         pitch  = (r < 10) ? 0 : ((r < 20) ? 65535 : $urandom_range(65535, 1));
         r      = $urandom_range(99);
         bpp    = (r < 85) ? $urandom_range(4, 1) : ((r < 90) ? 0 : $urandom_range(7, 5));
         if (p == 2) begin
            // A plain surface, so that the long hold really backs up the pipeline.
            width  = 640;
            height = 480;
            bpp    = 2;
         end
         program_surface(width, height, pitch, bpp, $urandom);
         steady_phase = (p == 1);
         if (p == 2) long_hold_pending = 1'b1;
         repeat (BYTES_PER_PHASE) send_random_byte();
         wait_drained();
         steady_phase = 1'b0;
      end

      $display("Covered %0d glyph bytes over %0d surface settings, %0d pixel writes checked.",
               bytes_sent, settings_used, blit_check.checked_count);
      if (blit_check.expected_writes.size() != 0)
         $display("ERROR: %0d pixel writes never arrived", blit_check.expected_writes.size());
      if (blit_check.error_count == 0 && blit_check.expected_writes.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
